// File: rtl/core/modular_arithmetic_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion shorthands for the modular arithmetic unit
// ---------------------------------------------------------------------------
`ifndef MODULAR_ARITHMETIC_UNIT_MACROS_SVH
`define MODULAR_ARITHMETIC_UNIT_MACROS_SVH

// condition holds at every rising clock edge outside reset
`define MAU_ASSERT_HOLD(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define MAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/mau_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mau_pkg
// Shared widths, codes and types of the modular arithmetic unit.
// ---------------------------------------------------------------------------
package mau_pkg;

   localparam int unsigned MAX_MODULUS_DEF = 256;

   localparam int unsigned ACT_W  = 3;
   localparam int unsigned OPD_W  = 8;
   localparam int unsigned EXP_W  = 16;
   localparam int unsigned RES_W  = 8;
   localparam int unsigned STAT_W = 2;
   localparam int unsigned CSR_W  = 9;

   typedef enum logic [ACT_W-1:0] {
      ACT_ADD  = 3'd0,
      ACT_SUB  = 3'd1,
      ACT_MUL  = 3'd2,
      ACT_DIV  = 3'd3,
      ACT_POW  = 3'd4,
      ACT_DLOG = 3'd5,
      ACT_ROOT = 3'd6
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK          = 2'd0,
      ST_BAD_OPERAND = 2'd1,
      ST_NO_INVERSE  = 2'd2,
      ST_NO_LOG      = 2'd3
   } status_type;

   // table write controls from the sequencer to the table memories
   typedef struct packed {
      logic inv_we;
      logic inv_none;
      logic flag_we;
      logic flag_bit;
   } mau_wr_type;

endpackage

// File: rtl/core/mau_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mau_req_if
// Request channel: action and operands, valid/ready.
// ---------------------------------------------------------------------------
interface mau_req_if import mau_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ACT_W-1:0]        action;
   logic [OPD_W-1:0]        operand_a;
   logic [OPD_W-1:0]        operand_b;
   logic signed [EXP_W-1:0] exponent;

   modport source (output valid, action, operand_a, operand_b, exponent, input ready);
   modport sink   (input valid, action, operand_a, operand_b, exponent, output ready);
endinterface

// File: rtl/core/mau_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mau_rsp_if
// Response channel: residue and status, valid/ready.
// ---------------------------------------------------------------------------
interface mau_rsp_if import mau_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RES_W-1:0]  result;
   logic [STAT_W-1:0] status;

   modport source (output valid, result, status, input ready);
   modport sink   (input valid, result, status, output ready);
endinterface

// File: rtl/core/mau_modmul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mau_modmul
// Bit-serial modular multiplier, one multiplier bit per cycle (MSB first).
// ---------------------------------------------------------------------------
module mau_modmul import mau_pkg::*; #(
   parameter int unsigned RW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear,
   input  logic          start,
   input  logic [RW-1:0] x,
   input  logic [RW-1:0] y,
   input  logic [RW:0]   n,
   output logic          done,
   output logic [RW-1:0] prod
);
   localparam int unsigned CNT_W = $clog2(RW + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [RW-1:0]    x_ff, x_in;
   logic [RW-1:0]    y_ff, y_in;
   logic [RW-1:0]    r_ff, r_in;

   logic [RW:0] dbl, dbl_r, add, add_r;

   // r = 2r + bit*x, each term folded back below n
   always_comb begin
      dbl   = {r_ff, 1'b0};
      dbl_r = (dbl >= n) ? dbl - n : dbl;
      add   = dbl_r + (y_ff[RW-1] ? {1'b0, x_ff} : '0);
      add_r = (add >= n) ? add - n : add;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      r_in    = r_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(RW);
         x_in    = x;
         y_in    = y;
         r_in    = '0;
      end else if (busy_ff) begin
         r_in   = add_r[RW-1:0];
         y_in   = y_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (clear) begin
         busy_in = 1'b0;
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      r_ff <= r_in;
   end

   assign done = done_ff;
   assign prod = r_ff;
endmodule

// File: rtl/core/mau_tables.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mau_tables
// Inverse table and primitive-root flag table, registered reads.
// ---------------------------------------------------------------------------
module mau_tables import mau_pkg::*; #(
   parameter int unsigned DEPTH = MAX_MODULUS_DEF,
   parameter int unsigned RW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic [RW-1:0] inv_raddr,
   input  logic [RW-1:0] flag_raddr,
   input  logic [RW-1:0] waddr,
   input  mau_wr_type    wr,
   input  logic [RW-1:0] inv_wdata,
   output logic [RW:0]   inv_rdata,
   output logic          flag_rdata
);
   // inverse entry: top bit set means no inverse
   logic [RW:0] inv_mem  [DEPTH];
   logic        flag_mem [DEPTH];

   logic [RW:0] inv_rdata_ff;
   logic        flag_rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.inv_we) begin
         inv_mem[waddr] <= {wr.inv_none, inv_wdata};
      end
      if (wr.flag_we) begin
         flag_mem[waddr] <= wr.flag_bit;
      end
      inv_rdata_ff  <= inv_mem[inv_raddr];
      flag_rdata_ff <= flag_mem[flag_raddr];
   end

   assign inv_rdata  = inv_rdata_ff;
   assign flag_rdata = flag_rdata_ff;
endmodule

// File: rtl/core/mau_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mau_core
// Sequencer: table rebuild after reset or a modulus write, then one action at a time.
// ---------------------------------------------------------------------------
module mau_core import mau_pkg::*; #(
   parameter int unsigned MAX_MODULUS = MAX_MODULUS_DEF,
   localparam int unsigned RW = $clog2(MAX_MODULUS),
   localparam int unsigned NW = RW + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rebuild,
   input  logic [NW-1:0]           n,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ACT_W-1:0]        req_action,
   input  logic [OPD_W-1:0]        req_a,
   input  logic [OPD_W-1:0]        req_b,
   input  logic signed [EXP_W-1:0] req_exp,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [RES_W-1:0]        out_result,
   output logic [STAT_W-1:0]       out_status
);
   localparam int unsigned CW = (NW > OPD_W) ? NW : OPD_W;

   typedef enum logic [19:0] {
      S_INV        = 20'h00001,
      S_RT_RD      = 20'h00002,
      S_RT_CHK     = 20'h00004,
      S_RT_GO      = 20'h00008,
      S_RT_WAIT    = 20'h00010,
      S_IDLE       = 20'h00020,
      S_EXEC       = 20'h00040,
      S_DIV_CHK    = 20'h00080,
      S_MUL_GO     = 20'h00100,
      S_MUL_WAIT   = 20'h00200,
      S_POW        = 20'h00400,
      S_POW_R_WAIT = 20'h00800,
      S_POW_B_GO   = 20'h01000,
      S_POW_B_WAIT = 20'h02000,
      S_PINV_CHK   = 20'h04000,
      S_DLOG_CHK   = 20'h08000,
      S_DLOG_GO    = 20'h10000,
      S_DLOG_WAIT  = 20'h20000,
      S_ROOT_CHK   = 20'h40000,
      S_DONE       = 20'h80000
   } state_type;

   state_type        state_ff, state_in;
   action_type       act_ff, act_in;
   logic [RW-1:0]    a_ff, a_in;
   logic [RW-1:0]    b_ff, b_in;
   logic             a_bad_ff, a_bad_in;
   logic             b_bad_ff, b_bad_in;
   logic [EXP_W-1:0] e_ff, e_in;
   logic             neg_ff, neg_in;
   logic [RW-1:0]    acc_ff, acc_in;
   logic [NW-1:0]    cnt_ff, cnt_in;
   logic [RW-1:0]    i_ff, i_in;
   logic [RW-1:0]    phi_ff, phi_in;
   logic [RES_W-1:0] res_ff, res_in;
   status_type       st_ff, st_in;

   // datapath helpers
   logic [NW-1:0]    n_m1, p_sum, p_nx_w, j_nx, s_add, s_add_r, d_sub, s_sub;
   logic             i_last, hit, last, inv_none;
   logic [CW-1:0]    a_ext, b_ext, n_ext;
   logic [EXP_W-1:0] e_raw;

   // multiplier and tables
   logic          mm_start, mm_done;
   logic [RW-1:0] mm_x, mm_y, mm_prod;
   logic [RW-1:0] inv_raddr, flag_raddr;
   logic [RW:0]   inv_rdata;
   logic          flag_rdata;
   mau_wr_type    wr;

   mau_modmul #(.RW(RW)) u_modmul (
      .clock (clock),
      .reset (reset),
      .clear (rebuild),
      .start (mm_start),
      .x     (mm_x),
      .y     (mm_y),
      .n     (n),
      .done  (mm_done),
      .prod  (mm_prod)
   );

   mau_tables #(.DEPTH(MAX_MODULUS), .RW(RW)) u_tables (
      .clock      (clock),
      .inv_raddr  (inv_raddr),
      .flag_raddr (flag_raddr),
      .waddr      (i_ff),
      .wr         (wr),
      .inv_wdata  (j_nx[RW-1:0]),
      .inv_rdata  (inv_rdata),
      .flag_rdata (flag_rdata)
   );

   always_comb begin
      n_m1     = n - 1'b1;
      i_last   = ({1'b0, i_ff} == n_m1);
      p_sum    = {1'b0, acc_ff} + {1'b0, i_ff};
      p_nx_w   = (p_sum >= n) ? p_sum - n : p_sum;
      j_nx     = cnt_ff + 1'b1;
      hit      = (p_nx_w == NW'(1));
      last     = (j_nx >= n_m1);
      inv_none = inv_rdata[RW];
      s_add    = {1'b0, a_ff} + {1'b0, b_ff};
      s_add_r  = (s_add >= n) ? s_add - n : s_add;
      d_sub    = {1'b0, a_ff} - {1'b0, b_ff};
      s_sub    = (a_ff >= b_ff) ? d_sub : d_sub + n;
      a_ext    = CW'(req_a);
      b_ext    = CW'(req_b);
      n_ext    = CW'(n);
      e_raw    = req_exp;
   end

   // multiplier operands and table read addresses by state
   always_comb begin
      mm_start   = 1'b0;
      mm_x       = acc_ff;
      mm_y       = b_ff;
      inv_raddr  = i_ff;
      flag_raddr = a_ff;
      case (state_ff)
         S_RT_GO: begin
            mm_start = 1'b1;
            mm_y     = i_ff;
         end
         S_MUL_GO: begin
            mm_start = 1'b1;
            mm_x     = a_ff;
         end
         S_POW: begin
            mm_start  = (e_ff != '0);
            mm_x      = e_ff[0] ? acc_ff : a_ff;
            mm_y      = a_ff;
            inv_raddr = acc_ff;
         end
         S_POW_B_GO: begin
            mm_start = 1'b1;
            mm_x     = a_ff;
            mm_y     = a_ff;
         end
         S_DLOG_GO: begin
            mm_start = 1'b1;
         end
         S_EXEC: begin
            inv_raddr  = (act_ff == ACT_DIV) ? b_ff : a_ff;
            flag_raddr = (act_ff == ACT_DLOG) ? b_ff : a_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      act_in   = act_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      a_bad_in = a_bad_ff;
      b_bad_in = b_bad_ff;
      e_in     = e_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      i_in     = i_ff;
      phi_in   = phi_ff;
      res_in   = res_ff;
      st_in    = st_ff;
      wr       = '0;

      case (state_ff)
         // pass 1: linear walk i*j mod n finds the inverse of i
         S_INV: begin
            cnt_in = j_nx;
            if (hit || last) begin
               wr.inv_we   = 1'b1;
               wr.inv_none = !hit;
               wr.flag_we  = 1'b1;
               wr.flag_bit = 1'b0;
               acc_in      = '0;
               cnt_in      = '0;
               phi_in      = phi_ff + RW'(hit);
               if (i_last) begin
                  i_in     = '0;
                  state_in = S_RT_RD;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               acc_in = p_nx_w[RW-1:0];
            end
         end
         // pass 2: order of each unit; root when the order equals phi
         S_RT_RD: begin
            state_in = S_RT_CHK;
         end
         S_RT_CHK: begin
            if (inv_none) begin
               if (i_last) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_RT_RD;
               end
            end else begin
               acc_in   = RW'(1);
               cnt_in   = '0;
               state_in = S_RT_GO;
            end
         end
         S_RT_GO: begin
            state_in = S_RT_WAIT;
         end
         S_RT_WAIT: begin
            if (mm_done) begin
               if (mm_prod == RW'(1)) begin
                  wr.flag_we  = 1'b1;
                  wr.flag_bit = (j_nx == {1'b0, phi_ff});
                  if (i_last) begin
                     state_in = S_IDLE;
                  end else begin
                     i_in     = i_ff + 1'b1;
                     state_in = S_RT_RD;
                  end
               end else begin
                  acc_in   = mm_prod;
                  cnt_in   = j_nx;
                  state_in = S_RT_GO;
               end
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               act_in   = action_type'(req_action);
               a_bad_in = (a_ext >= n_ext);
               b_bad_in = (b_ext >= n_ext);
               a_in     = a_ext[RW-1:0];
               b_in     = b_ext[RW-1:0];
               neg_in   = e_raw[EXP_W-1];
               e_in     = e_raw[EXP_W-1] ? (~e_raw + 1'b1) : e_raw;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_in   = '0;
            st_in    = ST_OK;
            state_in = S_DONE;
            case (act_ff)
               ACT_ADD: begin
                  if (a_bad_ff || b_bad_ff) st_in = ST_BAD_OPERAND;
                  else res_in = RES_W'(s_add_r);
               end
               ACT_SUB: begin
                  if (a_bad_ff || b_bad_ff) st_in = ST_BAD_OPERAND;
                  else res_in = RES_W'(s_sub);
               end
               ACT_MUL: begin
                  if (a_bad_ff || b_bad_ff) st_in = ST_BAD_OPERAND;
                  else state_in = S_MUL_GO;
               end
               ACT_DIV: begin
                  if (a_bad_ff || b_bad_ff) st_in = ST_BAD_OPERAND;
                  else if (b_ff == '0) st_in = ST_NO_INVERSE;
                  else state_in = S_DIV_CHK;
               end
               ACT_POW: begin
                  if (a_bad_ff) begin
                     st_in = ST_BAD_OPERAND;
                  end else begin
                     acc_in   = (n == NW'(1)) ? '0 : RW'(1);
                     state_in = S_POW;
                  end
               end
               ACT_DLOG: begin
                  if (b_ff <= RW'(1) || b_bad_ff || a_ff == '0 || a_bad_ff)
                     st_in = ST_BAD_OPERAND;
                  else
                     state_in = S_DLOG_CHK;
               end
               ACT_ROOT: begin
                  if (a_bad_ff) st_in = ST_BAD_OPERAND;
                  else state_in = S_ROOT_CHK;
               end
               default: begin
                  st_in = ST_BAD_OPERAND;
               end
            endcase
         end
         S_DIV_CHK: begin
            if (inv_none) begin
               st_in    = ST_NO_INVERSE;
               state_in = S_DONE;
            end else begin
               b_in     = inv_rdata[RW-1:0];
               state_in = S_MUL_GO;
            end
         end
         S_MUL_GO: begin
            state_in = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (mm_done) begin
               res_in   = RES_W'(mm_prod);
               state_in = S_DONE;
            end
         end
         // square-and-multiply, LSB first; a_ff carries the running square
         S_POW: begin
            if (e_ff == '0) begin
               if (neg_ff) begin
                  state_in = S_PINV_CHK;
               end else begin
                  res_in   = RES_W'(acc_ff);
                  state_in = S_DONE;
               end
            end else if (e_ff[0]) begin
               state_in = S_POW_R_WAIT;
            end else begin
               state_in = S_POW_B_WAIT;
            end
         end
         S_POW_R_WAIT: begin
            if (mm_done) begin
               acc_in   = mm_prod;
               state_in = S_POW_B_GO;
            end
         end
         S_POW_B_GO: begin
            state_in = S_POW_B_WAIT;
         end
         S_POW_B_WAIT: begin
            if (mm_done) begin
               a_in     = mm_prod;
               e_in     = e_ff >> 1;
               state_in = S_POW;
            end
         end
         S_PINV_CHK: begin
            if (inv_none) st_in = ST_NO_INVERSE;
            else res_in = RES_W'(inv_rdata[RW-1:0]);
            state_in = S_DONE;
         end
         S_DLOG_CHK: begin
            if (!flag_rdata || inv_none) begin
               st_in    = ST_NO_LOG;
               state_in = S_DONE;
            end else if (a_ff == RW'(1)) begin
               state_in = S_DONE;
            end else begin
               acc_in   = RW'(1);
               cnt_in   = '0;
               state_in = S_DLOG_GO;
            end
         end
         S_DLOG_GO: begin
            state_in = S_DLOG_WAIT;
         end
         S_DLOG_WAIT: begin
            if (mm_done) begin
               cnt_in = j_nx;
               if (mm_prod == a_ff) begin
                  res_in   = RES_W'(j_nx);
                  state_in = S_DONE;
               end else if (j_nx == n) begin
                  st_in    = ST_NO_LOG;
                  state_in = S_DONE;
               end else begin
                  acc_in   = mm_prod;
                  state_in = S_DLOG_GO;
               end
            end
         end
         S_ROOT_CHK: begin
            res_in   = RES_W'(flag_rdata);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a new modulus restarts the table build
      if (rebuild) begin
         state_in = S_INV;
         i_in     = '0;
         acc_in   = '0;
         cnt_in   = '0;
         phi_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INV;
         i_ff     <= '0;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         phi_ff   <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         phi_ff   <= phi_in;
      end
      act_ff   <= act_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      a_bad_ff <= a_bad_in;
      b_bad_ff <= b_bad_in;
      e_ff     <= e_in;
      neg_ff   <= neg_in;
      res_ff   <= res_in;
      st_ff    <= st_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign out_valid  = (state_ff == S_DONE);
   assign out_result = res_ff;
   assign out_status = st_ff;
endmodule

// File: rtl/core/modular_arithmetic_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// modular_arithmetic_unit
// Modular ALU over a programmable modulus with inverse and root tables.
// ---------------------------------------------------------------------------
//
//   channel   dir   handshake       payload
//   req_if    in    valid/ready     action, operand_a, operand_b, exponent
//   rsp_if    out   valid/ready     result, status
//   csr       in    csr_we          csr_wdata (modulus)
//
// Mul, div, power and dlog run on the serial modmul; add, sub, error and
//   root-test requests do not.
// Reset and every modulus write rebuild the tables while req_if.ready is low:
//   an inverse walk, then an order walk. Reset gives modulus 1.
// A finished response sits in an output register; the next request is taken
//   while it waits. The core stalls only when a second response is ready.
// Table reads follow long-finished writes, so no forwarding is needed.
// ---------------------------------------------------------------------------
`include "modular_arithmetic_unit_macros.svh"

module modular_arithmetic_unit import mau_pkg::*; #(
   parameter int unsigned MAX_MODULUS = MAX_MODULUS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   mau_req_if.sink          req_if,
   mau_rsp_if.source        rsp_if,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);
   localparam int unsigned RW   = $clog2(MAX_MODULUS);
   localparam int unsigned NW   = RW + 1;
   localparam int unsigned CMPW = (NW > CSR_W) ? NW : CSR_W;

   // modulus register, zero reads as 1, large values clamp to the maximum
   logic [NW-1:0]   n_ff, n_in;
   logic [CMPW-1:0] wdata_ext;

   always_comb begin
      wdata_ext = CMPW'(csr_wdata);
      n_in      = n_ff;
      if (csr_we) begin
         if (wdata_ext == '0)
            n_in = NW'(1);
         else if (wdata_ext > CMPW'(MAX_MODULUS))
            n_in = NW'(MAX_MODULUS);
         else
            n_in = wdata_ext[NW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) n_ff <= NW'(1);
      else n_ff <= n_in;
   end

   // sequencer with multiplier and tables
   logic              core_valid, core_ready;
   logic [RES_W-1:0]  core_result;
   logic [STAT_W-1:0] core_status;

   mau_core #(.MAX_MODULUS(MAX_MODULUS)) u_core (
      .clock      (clock),
      .reset      (reset),
      .rebuild    (csr_we),
      .n          (n_ff),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .req_action (req_if.action),
      .req_a      (req_if.operand_a),
      .req_b      (req_if.operand_b),
      .req_exp    (req_if.exponent),
      .out_valid  (core_valid),
      .out_ready  (core_ready),
      .out_result (core_result),
      .out_status (core_status)
   );

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0]  rsp_result_ff, rsp_result_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;

   assign core_ready = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_status_in = rsp_status_ff;
      if (core_valid && core_ready) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = core_result;
         rsp_status_in = core_status;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
      rsp_result_ff <= rsp_result_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.result = rsp_result_ff;
   assign rsp_if.status = rsp_status_ff;

   // checks
   `MAU_ASSERT_NEXT(a_rebuild_blocks, clock, reset, csr_we, !req_if.ready, "request taken during table rebuild")
   `MAU_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_if.valid && req_if.ready, !req_if.ready, "second request taken while busy")
   `MAU_ASSERT_HOLD(a_err_zero, clock, reset, !rsp_if.valid || rsp_if.status == ST_OK || rsp_if.result == '0, "error response with nonzero result")
endmodule

// File: bench/tb_modular_arithmetic_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_modular_arithmetic_unit
// Self-checking bench: random rows at modulus 1, directed rows at modulus 13,
// then random traffic over several moduli (small, prime, composite, zero and
// saturating writes), checked against typed values or a residue calculator.
// ---------------------------------------------------------------------------
module tb_modular_arithmetic_unit;
   import mau_pkg::*;

   localparam logic [ACT_W-1:0] ACT_UNDEF = 3'd7;
   localparam int DRAIN_CYCLES = 3000;       // outlasts the longest dlog at n = 256
   localparam int STALL_LIMIT  = 1_000_000;  // outlasts a table rebuild at n = 256
   localparam int NUM_DIRECTED = 24;
   localparam int NUM_PHASES   = 6;

   typedef struct {
      logic [ACT_W-1:0]        act;
      logic [OPD_W-1:0]        a;
      logic [OPD_W-1:0]        b;
      logic signed [EXP_W-1:0] e;
      bit                      fixed;   // expected value typed into the row
      logic [RES_W-1:0]        res;
      status_type              st;
   } op_row_type;

   typedef struct {
      logic [RES_W-1:0] res;
      status_type       st;
   } residue_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic             csr_we    = 1'b0;
   logic [CSR_W-1:0] csr_wdata = '0;

   mau_req_if req_if ();
   mau_rsp_if rsp_if ();

   modular_arithmetic_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Residue calculator: own copy of modulus, inverse table and root flags
   // ------------------------------------------------------------------------
   int unsigned mod_n;
   int unsigned inv_tab [256];   // 256 marks "no inverse"
   bit          root_tab[256];
   int unsigned root_list[$];

   residue_type expected_q[$];
   int          mismatch_count = 0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   function automatic int unsigned gcd(int unsigned x, int unsigned y);
      int unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic void load_modulus(int unsigned raw);
      int unsigned n, phi, p;
      bit ok;
      bit seen[256];
      n = raw & 9'h1ff;
      if (n == 0) n = 1;
      if (n > 256) n = 256;
      mod_n = n;
      root_list.delete();
      for (int i = 0; i < 256; i++) begin
         inv_tab[i]  = 256;
         root_tab[i] = 1'b0;
      end
      for (int unsigned i = 1; i < n; i++) begin
         for (int unsigned j = 1; j < n; j++) begin
            if ((i * j) % n == 1) begin
               inv_tab[i] = j;
               break;
            end
         end
      end
      phi = 0;
      for (int unsigned i = 1; i <= n; i++)
         if (gcd(i, n) == 1) phi++;
      // a root walks through phi distinct units before repeating
      for (int unsigned i = 1; i < n; i++) begin
         foreach (seen[k]) seen[k] = 1'b0;
         p  = 1;
         ok = 1'b1;
         for (int unsigned j = 0; j < phi; j++) begin
            p = (p * i) % n;
            if (gcd(p, n) != 1 || seen[p]) begin
               ok = 1'b0;
               break;
            end
            seen[p] = 1'b1;
         end
         root_tab[i] = ok;
         if (ok) root_list.push_back(i);
      end
   endfunction

   function automatic residue_type calc_residue(op_row_type op);
      residue_type r;
      int unsigned n, a, b, mag, acc, base, k, p;
      bit          found;
      n = mod_n;
      a = op.a;
      b = op.b;
      r.res = '0;
      r.st  = ST_OK;
      case (op.act)
         ACT_ADD, ACT_SUB, ACT_MUL: begin
            if (a >= n || b >= n) r.st = ST_BAD_OPERAND;
            else if (op.act == ACT_ADD) r.res = RES_W'((a + b) % n);
            else if (op.act == ACT_SUB) r.res = RES_W'((a >= b) ? a - b : a + n - b);
            else r.res = RES_W'((a * b) % n);
         end
         ACT_DIV: begin
            if (a >= n || b >= n) r.st = ST_BAD_OPERAND;
            else if (b == 0 || inv_tab[b] == 256) r.st = ST_NO_INVERSE;
            else r.res = RES_W'((a * inv_tab[b]) % n);
         end
         ACT_POW: begin
            if (a >= n) r.st = ST_BAD_OPERAND;
            else begin
               mag  = (op.e < 0) ? 32'(-int'(op.e)) : 32'(op.e);
               acc  = 1 % n;
               base = a % n;
               while (mag != 0) begin
                  if (mag[0]) acc = (acc * base) % n;
                  base = (base * base) % n;
                  mag  = mag >> 1;
               end
               if (op.e < 0) begin
                  if (inv_tab[acc] == 256) r.st = ST_NO_INVERSE;
                  else acc = inv_tab[acc];
               end
               r.res = acc[RES_W-1:0];
            end
         end
         ACT_DLOG: begin
            if (b <= 1 || b >= n || a == 0 || a >= n) r.st = ST_BAD_OPERAND;
            else if (!root_tab[b] || gcd(a, n) != 1) r.st = ST_NO_LOG;
            else if (a != 1) begin
               p = 1;
               k = 0;
               found = 1'b0;
               while (k < n) begin
                  p = (p * b) % n;
                  k++;
                  if (p == a) begin
                     found = 1'b1;
                     break;
                  end
               end
               if (found) r.res = k[RES_W-1:0];
               else r.st = ST_NO_LOG;
            end
         end
         ACT_ROOT: begin
            if (a >= n) r.st = ST_BAD_OPERAND;
            else r.res = RES_W'(root_tab[a]);
         end
         default: r.st = ST_BAD_OPERAND;
      endcase
      if (r.st != ST_OK) r.res = '0;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: changes happen only at a falling clock edge
   // ------------------------------------------------------------------------
   initial begin
      req_if.valid     = 1'b0;
      req_if.action    = '0;
      req_if.operand_a = '0;
      req_if.operand_b = '0;
      req_if.exponent  = '0;
      rsp_if.ready     = 1'b0;
   end

   task automatic send_op(op_row_type op);
      residue_type want;
      // random sender gaps
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid     <= 1'b1;
      req_if.action    <= op.act;
      req_if.operand_a <= op.a;
      req_if.operand_b <= op.b;
      req_if.exponent  <= op.e;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      // the transfer is done; its response can come no earlier than next edge
      if (op.fixed) begin
         want.res = op.res;
         want.st  = op.st;
      end else begin
         want = calc_residue(op);
      end
      expected_q.push_back(want);
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // modulus writes happen only with nothing in flight
   task automatic write_modulus(logic [CSR_W-1:0] value);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      load_modulus(value);
   endtask

   // random op: mostly well formed, with a slice of out-of-range noise
   function automatic op_row_type pick_op();
      op_row_type op;
      int unsigned n, tries;
      n = mod_n;
      op.fixed = 1'b0;
      op.res   = '0;
      op.st    = ST_OK;
      if ($urandom_range(99) < 12) begin
         op.act = 3'($urandom_range(7));
         op.a   = 8'($urandom);
         op.b   = 8'($urandom);
      end else begin
         op.act = 3'($urandom_range(6));
         op.a   = 8'($urandom_range(n - 1));
         op.b   = 8'($urandom_range(n - 1));
         if (op.act == ACT_DLOG && n > 2) begin
            // a root base and a unit value reach the search loop
            if (root_list.size() != 0 && $urandom_range(9) != 0)
               op.b = 8'(root_list[$urandom_range(root_list.size() - 1)]);
            tries = 0;
            do begin
               op.a = 8'($urandom_range(n - 1, 1));
               tries++;
            end while (gcd(op.a, n) != 1 && tries < 8 && $urandom_range(9) != 0);
         end
      end
      case ($urandom_range(3))
         0: op.e = 16'($urandom);
         1: op.e = 16'(int'($urandom_range(16)) - 8);
         2: op.e = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         default: op.e = 16'($urandom_range(300));
      endcase
      return op;
   endfunction

   // ------------------------------------------------------------------------
   // Response side: random stalls, in-order check at rising edges
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_if.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      residue_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected response: result %0d status %0d",
                   rsp_if.result, rsp_if.status);
            mismatch_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_if.result !== want.res) begin
               $error("result: expected %0d, got %0d", want.res, rsp_if.result);
               mismatch_count++;
            end
            if (rsp_if.status !== want.st) begin
               $error("status: expected %0d, got %0d", want.st, rsp_if.status);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: cycles without any transfer or register write
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Directed rows at modulus 13 (roots 2, 6, 7, 11; 3 has order 3)
   // ------------------------------------------------------------------------
   op_row_type directed[NUM_DIRECTED];

   initial begin
      directed = '{
         '{ACT_ADD,  8'd0,   8'd0,   16'sd0,     1'b0, 8'd0, ST_OK},
         '{ACT_ADD,  8'd12,  8'd12,  16'sd0,     1'b0, 8'd0, ST_OK},
         '{ACT_ADD,  8'd13,  8'd0,   16'sd0,     1'b1, 8'd0, ST_BAD_OPERAND},
         '{ACT_SUB,  8'd0,   8'd12,  16'sd0,     1'b0, 8'd0, ST_OK},
         '{ACT_SUB,  8'd12,  8'd255, 16'sd0,     1'b1, 8'd0, ST_BAD_OPERAND},
         '{ACT_MUL,  8'd12,  8'd12,  16'sd0,     1'b0, 8'd0, ST_OK},
         '{ACT_MUL,  8'd255, 8'd255, 16'sd0,     1'b1, 8'd0, ST_BAD_OPERAND},
         '{ACT_DIV,  8'd7,   8'd0,   16'sd0,     1'b1, 8'd0, ST_NO_INVERSE},
         '{ACT_DIV,  8'd12,  8'd5,   16'sd0,     1'b0, 8'd0, ST_OK},
         '{ACT_POW,  8'd0,   8'd0,   16'sd0,     1'b1, 8'd1, ST_OK},
         '{ACT_POW,  8'd2,   8'd0,   16'sh7fff,  1'b0, 8'd0, ST_OK},
         '{ACT_POW,  8'd2,   8'd0,   16'sh8000,  1'b0, 8'd0, ST_OK},
         '{ACT_POW,  8'd0,   8'd0,   -16'sd1,    1'b1, 8'd0, ST_NO_INVERSE},
         '{ACT_POW,  8'd13,  8'd0,   16'sd5,     1'b1, 8'd0, ST_BAD_OPERAND},
         '{ACT_DLOG, 8'd1,   8'd2,   16'sd0,     1'b1, 8'd0, ST_OK},
         '{ACT_DLOG, 8'd5,   8'd1,   16'sd0,     1'b1, 8'd0, ST_BAD_OPERAND},
         '{ACT_DLOG, 8'd0,   8'd2,   16'sd0,     1'b1, 8'd0, ST_BAD_OPERAND},
         '{ACT_DLOG, 8'd5,   8'd13,  16'sd0,     1'b1, 8'd0, ST_BAD_OPERAND},
         '{ACT_DLOG, 8'd5,   8'd3,   16'sd0,     1'b1, 8'd0, ST_NO_LOG},
         '{ACT_DLOG, 8'd12,  8'd2,   16'sd0,     1'b0, 8'd0, ST_OK},
         '{ACT_ROOT, 8'd2,   8'd0,   16'sd0,     1'b0, 8'd0, ST_OK},
         '{ACT_ROOT, 8'd12,  8'd0,   16'sd0,     1'b0, 8'd0, ST_OK},
         '{ACT_ROOT, 8'd13,  8'd0,   16'sd0,     1'b1, 8'd0, ST_BAD_OPERAND},
         '{ACT_UNDEF, 8'd3,  8'd4,   16'sd0,     1'b1, 8'd0, ST_BAD_OPERAND}
      };
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   // zero writes as 1, 511 saturates to 256 and sets every data bit
   logic [CSR_W-1:0] phase_modulus[NUM_PHASES] = '{9'd0, 9'd2, 9'd9, 9'd97, 9'd36, 9'd511};
   int               phase_items  [NUM_PHASES] = '{30, 60, 150, 200, 160, 150};
   int               send_pct_tab [4] = '{0, 48, 0, 33};
   int               recv_pct_tab [4] = '{0, 0, 48, 33};

   initial begin
      int mode;
      load_modulus(1);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // a few transfers at the reset modulus of 1
      for (int i = 0; i < 16; i++) send_op(pick_op());
      drop_valid();

      write_modulus(9'd13);
      foreach (directed[i]) send_op(directed[i]);
      drop_valid();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_modulus(phase_modulus[ph]);
         for (int i = 0; i < phase_items[ph]; i++) begin
            // each phase cycles through the four idle patterns
            mode = (i * 4) / phase_items[ph];
            send_idle_pct  = send_pct_tab[mode];
            recv_stall_pct = recv_pct_tab[mode];
            // hold off once until everything has come back
            if (ph == 2 && i == 40) begin
               drop_valid();
               wait_drained();
            end
            send_op(pick_op());
         end
         drop_valid();
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/mau_pkg.sv
rtl/core/mau_req_if.sv
rtl/core/mau_rsp_if.sv
rtl/core/mau_modmul.sv
rtl/core/mau_tables.sv
rtl/core/mau_core.sv
rtl/core/modular_arithmetic_unit.sv
bench/tb_modular_arithmetic_unit.sv
